@@ rtl/core/qps_pkg.sv @@
// Shared widths, register indexes and helper functions for the quadrature
// pulse spreader. No dependencies.
package qps_pkg;

  localparam int LineW  = 10;  // scanline and frame height
  localparam int CountW = 11;  // pending step count, 0..1024
  localparam int DeltaW = 12;  // signed motion delta
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 10;
  localparam int DivCntW = $clog2(LineW + 1);

  localparam logic [CfgIdxW-1:0] CfgMouseEnabled = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight  = 2'd1;

  localparam logic [LineW-1:0] FrameHeightRst = 10'd210;

  typedef logic [1:0] pos_t;

  // |floor(v/2)| of a two's complement delta
  function automatic logic [CountW-1:0] half_mag(input logic [DeltaW-1:0] v);
    logic [DeltaW-1:0] s;
    logic [DeltaW-1:0] n;
    s = {v[DeltaW-1], v[DeltaW-1:1]};
    n = '0 - s;
    if (s[DeltaW-1]) begin
      return n[CountW-1:0];
    end
    return s[CountW-1:0];
  endfunction

  // vertical pair: positions 0..3 -> 0,1,3,2
  function automatic logic [1:0] gray_v(input pos_t p);
    logic [1:0] g;
    case (p)
      2'd0: g = 2'b00;
      2'd1: g = 2'b01;
      2'd2: g = 2'b11;
      2'd3: g = 2'b10;
      default: g = 2'b00;
    endcase
    return g;
  endfunction

  // horizontal pair: positions 0..3 -> 0,2,3,1
  function automatic logic [1:0] gray_h(input pos_t p);
    logic [1:0] g;
    case (p)
      2'd0: g = 2'b00;
      2'd1: g = 2'b10;
      2'd2: g = 2'b11;
      2'd3: g = 2'b01;
      default: g = 2'b00;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/core/mouse_quadrature_pulse_spreader.sv @@
// Top level of the quadrature pulse spreader: sequencer, axis state and
// one shared mark adder/compare. Depends on qps_pkg and qps_divider.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  kind, scan_line, deltas, buttons
//   out      source     out_valid_o/out_stall_i port_nibble, fire_released
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A read item's result is ready once the single mark adder has stepped one spacing
// interval per cycle on the vertical axis and then on the horizontal axis.
// A motion item runs two 10-step serial divides in turn, horizontal then vertical.
// A disabled motion item skips to S_DONE. One item is worked on at a time; a
// finished result waits in the output register while the next item is taken,
// and a stalled output register holds the next result back.
// Reset is asynchronous and resets all axis state; cfg writes are always taken.
module mouse_quadrature_pulse_spreader (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [qps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [qps_pkg::LineW-1:0]    scan_line_i,
  input  logic signed [qps_pkg::DeltaW-1:0] delta_x_i,
  input  logic signed [qps_pkg::DeltaW-1:0] delta_y_i,
  input  logic                         button_left_i,
  input  logic                         button_right_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [3:0]                   port_nibble_o,
  output logic                         fire_released_o
);
  import qps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_H, S_DIV_V, S_ADV_V, S_ADV_H, S_DONE
  } state_e;

  state_e            state_q;
  logic              enabled_q;
  logic [LineW-1:0]  frame_height_q;
  logic [LineW-1:0]  line_q;
  pos_t              phase_h_q, phase_v_q;
  logic [CountW-1:0] pending_h_q, pending_v_q;
  logic [LineW-1:0]  spacing_h_q, spacing_v_q;
  logic [LineW-1:0]  mark_h_q, mark_v_q;
  logic              dir_left_q, dir_down_q;
  logic              fire_q;
  logic              out_valid_q;
  logic [3:0]        nibble_q;
  logic              fire_out_q;

  logic              in_acc;
  logic              out_free;
  logic [CountW-1:0] hm_x, hm_y;
  logic              div_start;
  logic [CountW-1:0] div_divisor;
  logic              div_done;
  logic [LineW-1:0]  div_quot;
  logic [LineW-1:0]  spacing_new;
  logic [LineW-1:0]  add_a, add_b;
  logic [LineW:0]    add_sum;
  logic              add_lt;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign hm_x = half_mag(delta_x_i);
  assign hm_y = half_mag(delta_y_i);

  assign div_start   = (in_acc && kind_i && enabled_q) ||
                       (state_q == S_DIV_H && div_done);
  assign div_divisor = (state_q == S_IDLE) ? hm_y + CountW'(1) : pending_v_q + CountW'(1);
  assign spacing_new = (div_quot == '0) ? LineW'(1) : div_quot;

  qps_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (frame_height_q),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // one adder and compare serves both axes
  assign add_a   = (state_q == S_ADV_H) ? mark_h_q : mark_v_q;
  assign add_b   = (state_q == S_ADV_H) ? spacing_h_q : spacing_v_q;
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign add_lt  = add_sum < {1'b0, line_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      enabled_q      <= 1'b0;
      frame_height_q <= FrameHeightRst;
      phase_h_q      <= '0;
      phase_v_q      <= '0;
      pending_h_q    <= '0;
      pending_v_q    <= '0;
      spacing_h_q    <= LineW'(1);
      spacing_v_q    <= LineW'(1);
      mark_h_q       <= '0;
      mark_v_q       <= '0;
      dir_left_q     <= 1'b0;
      dir_down_q     <= 1'b0;
      fire_q         <= 1'b1;
      out_valid_q    <= 1'b0;
      line_q         <= '0;
      nibble_q       <= '0;
      fire_out_q     <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgMouseEnabled: enabled_q      <= cfg_data_i[0];
          CfgFrameHeight:  frame_height_q <= cfg_data_i[LineW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!kind_i) begin
              line_q <= scan_line_i;
              // drop marks left beyond the current line
              if (mark_h_q > scan_line_i) mark_h_q <= '0;
              if (mark_v_q > scan_line_i) mark_v_q <= '0;
              state_q <= S_ADV_V;
            end else if (enabled_q) begin
              dir_left_q  <= delta_y_i[DeltaW-1];
              dir_down_q  <= !delta_x_i[DeltaW-1];
              pending_h_q <= hm_y;
              pending_v_q <= hm_x;
              fire_q      <= !button_left_i && !button_right_i;
              state_q     <= S_DIV_H;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_DIV_H: begin
          if (div_done) begin
            spacing_h_q <= spacing_new;
            state_q     <= S_DIV_V;
          end
        end
        S_DIV_V: begin
          if (div_done) begin
            spacing_v_q <= spacing_new;
            state_q     <= S_DONE;
          end
        end
        S_ADV_V: begin
          if (add_lt) begin
            mark_v_q <= add_sum[LineW-1:0];
            if (pending_v_q != '0) begin
              phase_v_q   <= dir_down_q ? phase_v_q - 2'd1 : phase_v_q + 2'd1;
              pending_v_q <= pending_v_q - CountW'(1);
            end
          end else begin
            state_q <= S_ADV_H;
          end
        end
        S_ADV_H: begin
          if (add_lt) begin
            mark_h_q <= add_sum[LineW-1:0];
            if (pending_h_q != '0) begin
              phase_h_q   <= dir_left_q ? phase_h_q - 2'd1 : phase_h_q + 2'd1;
              pending_h_q <= pending_h_q - CountW'(1);
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            nibble_q    <= {gray_h(phase_h_q), gray_v(phase_v_q)};
            fire_out_q  <= fire_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign port_nibble_o   = nibble_q;
  assign fire_released_o = fire_out_q;

endmodule

@@ rtl/core/qps_divider.sv @@
// Serial restoring divider, one quotient bit per cycle.
// Depends on qps_pkg for widths.
module qps_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [qps_pkg::LineW-1:0]  dividend_i,
  input  logic [qps_pkg::CountW-1:0] divisor_i,
  output logic                       done_o,
  output logic [qps_pkg::LineW-1:0]  quot_o
);
  import qps_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [CountW-1:0]  rem_q;
  logic [CountW-1:0]  dsr_q;
  logic [LineW-1:0]   quot_q;

  logic [CountW:0]    trial;
  logic [CountW:0]    diff;
  logic               fits;

  assign trial = {rem_q, quot_q[LineW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == DivCntW'(LineW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DivCntW'(LineW - 1)) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dsr_q  <= divisor_i;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits in CountW bits
      rem_q  <= fits ? diff[CountW-1:0] : trial[CountW-1:0];
      quot_q <= {quot_q[LineW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for mouse_quadrature_pulse_spreader: directed and random
// motion/read items, with a port-nibble tracker class as the scoreboard.
// Depends on qps_pkg and the block's RTL only.
module testbench;
  import qps_pkg::*;

  localparam logic KindRead   = 1'b0;
  localparam logic KindMotion = 1'b1;
  localparam int AxisV = 0;
  localparam int AxisH = 1;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;
  localparam int DrainCycles  = 20;
  localparam int CycleLimit   = 5_000_000;
  localparam int RandomPhases = 9;
  localparam int PhaseItems   = 58;

  typedef struct packed {
    logic [3:0] nibble;
    logic       fire;
  } port_word_t;

  // Tracks axis positions, step budgets and marks; queues the port word due
  // for every accepted item.
  class quad_port_tracker;
    bit         enabled;
    logic [9:0] frame_h;
    pos_t       pos [2];
    int         steps [2];
    int         gap [2];
    int         mark [2];
    bit         down [2];
    bit         fire;
    port_word_t due [$];
    int         errors;

    function new();
      enabled = 1'b0;
      frame_h = FrameHeightRst;
      for (int a = 0; a < 2; a++) begin
        pos[a] = '0;
        steps[a] = 0;
        gap[a] = 1;
        mark[a] = 0;
        down[a] = 1'b0;
      end
      fire = 1'b1;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgMouseEnabled: enabled = data[0];
        CfgFrameHeight: frame_h = data;
        default: ;
      endcase
    endfunction

    function int spacing_for(int count);
      int q;
      q = int'(frame_h) / (count + 1);
      return (q == 0) ? 1 : q;
    endfunction

    // magnitude of floor(d/2)
    function int half_steps(logic signed [DeltaW-1:0] d);
      int q;
      q = d;
      q = q >>> 1;
      return (q < 0) ? -q : q;
    endfunction

    function void sweep(int a, int line);
      if (mark[a] > line) mark[a] = 0;
      while (mark[a] + gap[a] < line) begin
        // marks keep advancing after the steps run out
        if (steps[a] != 0) begin
          pos[a] = down[a] ? pos[a] - 2'd1 : pos[a] + 2'd1;
          steps[a]--;
        end
        mark[a] += gap[a];
      end
    endfunction

    function void take_item(logic kind, logic [LineW-1:0] line,
                            logic signed [DeltaW-1:0] dx, logic signed [DeltaW-1:0] dy,
                            logic bl, logic br);
      port_word_t w;
      if (kind == KindRead) begin
        sweep(AxisV, int'(line));
        sweep(AxisH, int'(line));
      end else if (enabled) begin
        // Y motion drives the horizontal pair, X the vertical pair
        down[AxisH] = dy[DeltaW-1];
        down[AxisV] = !dx[DeltaW-1];
        steps[AxisH] = half_steps(dy);
        steps[AxisV] = half_steps(dx);
        gap[AxisH] = spacing_for(steps[AxisH]);
        gap[AxisV] = spacing_for(steps[AxisV]);
        fire = !bl && !br;
      end
      w.nibble = {pos[AxisH][1] ^ pos[AxisH][0], pos[AxisH][1],
                  pos[AxisV][1], pos[AxisV][1] ^ pos[AxisV][0]};
      w.fire = fire;
      due.push_back(w);
    endfunction

    function void match_port(logic [3:0] nibble, logic fire_out);
      port_word_t w;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got nibble %h fire %b",
                 $time, nibble, fire_out);
        errors++;
        return;
      end
      w = due.pop_front();
      if (nibble !== w.nibble) begin
        $display("%0t: port_nibble expected %h got %h", $time, w.nibble, nibble);
        errors++;
      end
      if (fire_out !== w.fire) begin
        $display("%0t: fire_released expected %b got %b", $time, w.fire, fire_out);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i = '0;
  logic [CfgDataW-1:0]        cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       kind_i = 1'b0;
  logic [LineW-1:0]           scan_line_i = '0;
  logic signed [DeltaW-1:0]   delta_x_i = '0;
  logic signed [DeltaW-1:0]   delta_y_i = '0;
  logic                       button_left_i = 1'b0;
  logic                       button_right_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [3:0]                 port_nibble_o;
  logic                       fire_released_o;

  quad_port_tracker tracker = new();
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  mouse_quadrature_pulse_spreader dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .scan_line_i    (scan_line_i),
    .delta_x_i      (delta_x_i),
    .delta_y_i      (delta_y_i),
    .button_left_i  (button_left_i),
    .button_right_i (button_right_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .port_nibble_o  (port_nibble_o),
    .fire_released_o(fire_released_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check each accepted result, then draw the stall for the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        tracker.match_port(port_nibble_o, fire_released_o);
        stall_left = stall_on ? $urandom_range(0, 11) : 0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(logic kind, logic [LineW-1:0] line,
                           logic signed [DeltaW-1:0] dx, logic signed [DeltaW-1:0] dy,
                           logic bl, logic br);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    scan_line_i <= line;
    delta_x_i <= dx;
    delta_y_i <= dy;
    button_left_i <= bl;
    button_right_i <= br;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_item(kind, line, dx, dy, bl, br);
  endtask

  task automatic send_read(logic [LineW-1:0] line);
    send_item(KindRead, line, DeltaW'($urandom), DeltaW'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  task automatic send_motion(logic signed [DeltaW-1:0] dx, logic signed [DeltaW-1:0] dy,
                             logic bl, logic br);
    send_item(KindMotion, LineW'($urandom), dx, dy, bl, br);
  endtask

  task automatic send_noise();
    send_item(1'($urandom), LineW'($urandom), DeltaW'($urandom), DeltaW'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  // Hold the sender until every result is back and the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
  endtask

  task automatic configure(bit en, logic [LineW-1:0] frame);
    logic [CfgDataW-1:0] d;
    settle();
    d = CfgDataW'($urandom);
    d[0] = en;
    write_reg(CfgMouseEnabled, d);
    write_reg(CfgFrameHeight, frame);
    // spare indexes must be ignored
    write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [DeltaW-1:0] rand_delta();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      v = $urandom_range(0, 80);
      return DeltaW'(v - 40);
    end
    if (r < 88) return DeltaW'($urandom);
    case ($urandom_range(0, 4))
      0: return 12'sh800;
      1: return 12'sh7ff;
      2: return 12'shfff;
      3: return 12'sh001;
      default: return 12'sh000;
    endcase
  endfunction

  function automatic logic [LineW-1:0] pick_frame(int phase);
    case (phase)
      0: return 10'd210;
      1: return 10'd0;
      2: return 10'd1023;
      3: return 10'd1;
      default: return $urandom_range(0, 1) ? LineW'($urandom)
                                           : LineW'($urandom_range(150, 320));
    endcase
  endfunction

  initial begin
    int sent;
    int line;
    int n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled after reset: motion must leave everything alone
    send_motion(12'sd100, -12'sd100, 1'b1, 1'b1);
    send_read(10'd500);
    configure(1'b1, 10'd210);
    send_motion(12'sh7ff, 12'sh800, 1'b1, 1'b0);
    send_read(10'd1023);
    send_read(10'd5);     // mark beyond the line is cleared
    send_read(10'd1023);
    send_motion(12'shfff, 12'sh001, 1'b0, 1'b1);
    send_read(10'd0);
    send_read(10'd1023);
    send_motion(12'sh800, 12'sh7ff, 1'b0, 1'b0);
    send_read(10'd300);
    send_read(10'd1023);
    send_motion(12'sh000, 12'sh000, 1'b1, 1'b1);
    send_read(10'd1023);
    configure(1'b1, 10'd0);
    send_motion(-12'sd20, 12'sd20, 1'b0, 1'b0);
    // new height applies only to later motion
    configure(1'b1, 10'd1023);
    send_read(10'd1023);
    send_motion(12'sh000, -12'sd3, 1'b0, 1'b0);
    send_read(10'd1023);
    send_read(10'd512);
    configure(1'b0, 10'd1023);
    send_motion(12'sd5, 12'sd5, 1'b1, 1'b1);
    send_read(10'd1023);

    for (int p = 0; p < RandomPhases; p++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      configure($urandom_range(0, 5) != 0, pick_frame(p));
      sent = 0;
      while (sent < PhaseItems) begin
        case ($urandom_range(0, 9))
          7, 8: begin
            send_noise();
            sent++;
          end
          9: begin
            send_read(LineW'($urandom));
            sent++;
          end
          default: begin
            // one frame: a motion item, then reads at rising scanlines
            send_motion(rand_delta(), rand_delta(), 1'($urandom), 1'($urandom));
            sent++;
            line = $urandom_range(0, 120);
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
              send_read(LineW'(line));
              sent++;
              line = line + $urandom_range(1, 400);
              if (line > 1023) line = 1023;
            end
          end
        endcase
        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
